/* rtl/lc3_instruction_core_top_macros.svh */
// Assertion macros for the LC-3 instruction core
`ifndef LC3_INSTRUCTION_CORE_TOP_MACROS_SVH
`define LC3_INSTRUCTION_CORE_TOP_MACROS_SVH
// Implication checked every clock, disabled in reset
`define LC3_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the next cycle
`define LC3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/lc3_pkg.sv */
// ----------------------------------------------------------------------------
// lc3_pkg
// Shared types and constants for the LC-3 instruction core.
// ----------------------------------------------------------------------------
package lc3_pkg;

  localparam int unsigned MemWordsDefault = 65536;
  localparam logic [15:0] StartPcReset = 16'h3000;
  localparam logic [2:0]  CcPos = 3'd1;
  localparam logic [2:0]  CcZero = 3'd2;
  localparam logic [2:0]  CcNeg = 3'd4;

  // opcodes
  localparam logic [3:0] OpBr   = 4'd0;
  localparam logic [3:0] OpAdd  = 4'd1;
  localparam logic [3:0] OpLd   = 4'd2;
  localparam logic [3:0] OpSt   = 4'd3;
  localparam logic [3:0] OpJsr  = 4'd4;
  localparam logic [3:0] OpAnd  = 4'd5;
  localparam logic [3:0] OpLdr  = 4'd6;
  localparam logic [3:0] OpStr  = 4'd7;
  localparam logic [3:0] OpRti  = 4'd8;
  localparam logic [3:0] OpNot  = 4'd9;
  localparam logic [3:0] OpLdi  = 4'd10;
  localparam logic [3:0] OpSti  = 4'd11;
  localparam logic [3:0] OpJmp  = 4'd12;
  localparam logic [3:0] OpRes  = 4'd13;
  localparam logic [3:0] OpLea  = 4'd14;
  localparam logic [3:0] OpTrap = 4'd15;

  // trap vectors
  localparam logic [7:0] TrapGetc = 8'h20;
  localparam logic [7:0] TrapOut  = 8'h21;
  localparam logic [7:0] TrapIn   = 8'h23;
  localparam logic [7:0] TrapHalt = 8'h25;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_MEM1,
    ST_MEM2,
    ST_EXEC,
    ST_DONE
  } state_t;

  // memory address source
  typedef enum logic [1:0] {
    ADDR_PC,
    ADDR_EA,
    ADDR_MDR,
    ADDR_LOAD
  } addr_sel_t;

  // controller to datapath
  typedef struct packed {
    addr_sel_t addr_sel;
    logic      mem_we;
    logic      ld_ir;
    logic      ld_mdr;
    logic      exec;
    logic      load_item;
    logic      out_valid;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] opcode;
    logic       stopped;
  } stat_t;

  function automatic logic [15:0] sext(input logic [15:0] v, input int unsigned bits);
    logic [15:0] r;
    r = v;
    for (int i = 0; i < 16; i++) begin
      if (i >= bits) r[i] = v[bits-1];
    end
    return r;
  endfunction

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    logic [2:0] c;
    if (v == 16'd0) c = CcZero;
    else if (v[15]) c = CcNeg;
    else c = CcPos;
    return c;
  endfunction

endpackage

/* rtl/lc3_instruction_core_top.sv */
// ----------------------------------------------------------------------------
// lc3_instruction_core_top
// LC-3 core: a load item writes one memory word; a step item runs one
// instruction through transfer, fetch, decode, execute and result, with MEM1
// added for LD, LDR, LDI and STI and MEM2 also for LDI, set by the single
// memory port, one access a cycle. A halted or faulted core answers a step
// without fetching. Each item gives one result, strobed by done for one cycle
// after the state update; the receiver cannot stall it. start_pc may be
// written while the core is idle.
// ----------------------------------------------------------------------------
`include "lc3_instruction_core_top_macros.svh"

module lc3_instruction_core_top #(
  parameter int unsigned MEM_WORDS = lc3_pkg::MemWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [15:0] load_address,
  input  logic [15:0] load_word,
  input  logic [7:0]  key_char,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [15:0] pc_now,
  output logic        char_valid,
  output logic [7:0]  char_out,
  output logic        halted,
  output logic        fault,
  output logic [2:0]  cond_code
);

  lc3_pkg::ctrl_t ctrl;
  lc3_pkg::stat_t stat;
  logic           step_seen;

  assign cfg_ready = 1'b1;
  assign step_seen = start && !busy && operation;
  assign done      = ctrl.out_valid;

  lc3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  lc3_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .step_seen    (step_seen),
    .load_address (load_address),
    .load_word    (load_word),
    .key_char     (key_char),
    .stat         (stat),
    .pc_now       (pc_now),
    .char_valid   (char_valid),
    .char_out     (char_out),
    .halted       (halted),
    .fault        (fault),
    .cond_code    (cond_code)
  );

  // checks
  `LC3_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "start not taken")
  `LC3_ASSERT_IMP(a_done_busy, done, busy, "result strobe while idle")
  `LC3_ASSERT_NEXT(a_halt_sticky, halted, halted, "halt flag dropped")
  `LC3_ASSERT_IMP(a_cc_onehot, 1'b1, $onehot(cond_code), "condition code not one-hot")

endmodule

/* rtl/lc3_ram.sv */
// ----------------------------------------------------------------------------
// lc3_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lc3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read first port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/lc3_ctrl.sv */
// ----------------------------------------------------------------------------
// lc3_ctrl
// Sequencer for load and step items.
// ----------------------------------------------------------------------------
module lc3_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           operation,
  input  lc3_pkg::stat_t stat,
  output logic           busy,
  output lc3_pkg::ctrl_t ctrl
);

  lc3_pkg::state_t state;
  lc3_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lc3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lc3_pkg::ST_IDLE: begin
        if (start) begin
          if (!operation || stat.stopped) state_next = lc3_pkg::ST_DONE;
          else state_next = lc3_pkg::ST_FETCH;
        end
      end
      lc3_pkg::ST_FETCH:  state_next = lc3_pkg::ST_DECODE;
      lc3_pkg::ST_DECODE: begin
        if (stat.opcode == lc3_pkg::OpLd || stat.opcode == lc3_pkg::OpLdr ||
            stat.opcode == lc3_pkg::OpLdi || stat.opcode == lc3_pkg::OpSti) begin
          state_next = lc3_pkg::ST_MEM1;
        end else begin
          state_next = lc3_pkg::ST_EXEC;
        end
      end
      lc3_pkg::ST_MEM1: begin
        if (stat.opcode == lc3_pkg::OpLdi) state_next = lc3_pkg::ST_MEM2;
        else state_next = lc3_pkg::ST_EXEC;
      end
      lc3_pkg::ST_MEM2:   state_next = lc3_pkg::ST_EXEC;
      // result is shown the cycle after the state update
      lc3_pkg::ST_EXEC:   state_next = lc3_pkg::ST_DONE;
      lc3_pkg::ST_DONE:   state_next = lc3_pkg::ST_IDLE;
      default:            state_next = lc3_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    ctrl.addr_sel = lc3_pkg::ADDR_PC;
    busy = (state != lc3_pkg::ST_IDLE);
    case (state)
      lc3_pkg::ST_IDLE: begin
        ctrl.addr_sel = lc3_pkg::ADDR_LOAD;
        ctrl.load_item = start && !operation;
        ctrl.mem_we = start && !operation;
      end
      lc3_pkg::ST_FETCH: begin
        ctrl.addr_sel = lc3_pkg::ADDR_PC;
      end
      lc3_pkg::ST_DECODE: begin
        ctrl.ld_ir = 1'b1;
        ctrl.addr_sel = lc3_pkg::ADDR_EA;
      end
      lc3_pkg::ST_MEM1: begin
        ctrl.ld_mdr = 1'b1;
        ctrl.addr_sel = lc3_pkg::ADDR_MDR;
      end
      lc3_pkg::ST_MEM2: begin
        ctrl.ld_mdr = 1'b1;
      end
      lc3_pkg::ST_EXEC: begin
        ctrl.exec = 1'b1;
        ctrl.addr_sel = (stat.opcode == lc3_pkg::OpSti) ? lc3_pkg::ADDR_MDR
                                                         : lc3_pkg::ADDR_EA;
        ctrl.mem_we = (stat.opcode == lc3_pkg::OpSt || stat.opcode == lc3_pkg::OpStr ||
                       stat.opcode == lc3_pkg::OpSti);
      end
      lc3_pkg::ST_DONE: begin
        ctrl.out_valid = 1'b1;
      end
      default: begin
        ctrl.out_valid = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/lc3_dpath.sv */
// ----------------------------------------------------------------------------
// lc3_dpath
// Register file, PC, condition code, memory and instruction execution.
// ----------------------------------------------------------------------------
module lc3_dpath #(
  parameter int unsigned MEM_WORDS = lc3_pkg::MemWordsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  lc3_pkg::ctrl_t ctrl,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data,
  input  logic           step_seen,
  input  logic [15:0]    load_address,
  input  logic [15:0]    load_word,
  input  logic [7:0]     key_char,
  output lc3_pkg::stat_t stat,
  output logic [15:0]    pc_now,
  output logic           char_valid,
  output logic [7:0]     char_out,
  output logic           halted,
  output logic           fault,
  output logic [2:0]     cond_code
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [15:0] regs [8];
  logic [15:0] pc;
  logic [2:0]  cc;
  logic        halt_flag;
  logic        fault_flag;
  logic [15:0] ir;
  logic [15:0] mdr;
  logic [15:0] key_hold;
  logic        any_step;

  logic [15:0] rdata;
  logic [15:0] mem_addr;
  logic [15:0] mem_wdata;
  logic [15:0] ins;
  logic [3:0]  op;
  logic [2:0]  dr;
  logic [2:0]  sr1;
  logic [15:0] off9;
  logic [15:0] off6;
  logic [15:0] opb;
  logic [15:0] pc_inc;
  logic [15:0] ea;

  // IR is loaded in decode from the RAM read data
  assign ins    = ctrl.ld_ir ? rdata : ir;
  assign op     = ins[15:12];
  assign dr     = ins[11:9];
  assign sr1    = ins[8:6];
  assign off9   = lc3_pkg::sext(ins, 9);
  assign off6   = lc3_pkg::sext(ins, 6);
  assign opb    = ins[5] ? lc3_pkg::sext(ins, 5) : regs[ins[2:0]];
  assign pc_inc = pc + 16'd1;
  assign ea     = (op == lc3_pkg::OpLdr || op == lc3_pkg::OpStr) ? regs[sr1] + off6
                                                               : pc_inc + off9;

  // memory port
  always_comb begin
    case (ctrl.addr_sel)
      lc3_pkg::ADDR_PC:   mem_addr = pc;
      lc3_pkg::ADDR_EA:   mem_addr = ea;
      lc3_pkg::ADDR_MDR:  mem_addr = (ctrl.ld_mdr) ? rdata : mdr;
      lc3_pkg::ADDR_LOAD: mem_addr = load_address;
      default:            mem_addr = pc;
    endcase
  end
  assign mem_wdata = ctrl.load_item ? load_word : regs[dr];

  lc3_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (ctrl.mem_we),
    .addr  (mem_addr[AW-1:0]),
    .wdata (mem_wdata),
    .rdata (rdata)
  );

  assign stat.opcode  = op;
  assign stat.stopped = halt_flag || fault_flag;

  // instruction and data holding registers; key captured at the step transfer
  always_ff @(posedge clk) begin
    if (ctrl.ld_ir) begin
      ir <= rdata;
    end
    if (ctrl.ld_mdr) begin
      mdr <= rdata;
    end
    if (step_seen) begin
      key_hold <= {8'd0, key_char};
    end
  end

  // architectural state and result
  always_ff @(posedge clk) begin
    logic [15:0] wv;
    logic        wen;
    logic [15:0] pcv;
    if (rst) begin
      for (int i = 0; i < 8; i++) regs[i] <= '0;
      pc         <= lc3_pkg::StartPcReset;
      cc         <= lc3_pkg::CcZero;
      halt_flag  <= 1'b0;
      fault_flag <= 1'b0;
      any_step   <= 1'b0;
      char_valid <= 1'b0;
      char_out   <= '0;
    end else begin
      wv  = '0;
      wen = 1'b0;
      pcv = pc_inc;
      if (step_seen) any_step <= 1'b1;
      if (cfg_we) begin
        if (!any_step && !step_seen) pc <= cfg_data;
      end
      if (ctrl.out_valid) begin
        char_valid <= 1'b0;
        char_out   <= '0;
      end
      if (ctrl.exec) begin
        case (op)
          lc3_pkg::OpBr: begin
            if ((dr & cc) != 3'd0) pcv = pc_inc + off9;
          end
          lc3_pkg::OpAdd: begin wv = regs[sr1] + opb; wen = 1'b1; end
          lc3_pkg::OpAnd: begin wv = regs[sr1] & opb; wen = 1'b1; end
          lc3_pkg::OpNot: begin wv = ~regs[sr1]; wen = 1'b1; end
          lc3_pkg::OpLd, lc3_pkg::OpLdr, lc3_pkg::OpLdi: begin
            wv = mdr; wen = 1'b1;
          end
          lc3_pkg::OpLea: begin wv = pc_inc + off9; wen = 1'b1; end
          lc3_pkg::OpJsr: begin
            regs[7] <= pc_inc;
            pcv = ins[11] ? pc_inc + lc3_pkg::sext(ins, 11) : regs[sr1];
          end
          lc3_pkg::OpJmp: pcv = regs[sr1];
          lc3_pkg::OpSt, lc3_pkg::OpStr, lc3_pkg::OpSti: begin
          end
          lc3_pkg::OpTrap: begin
            regs[7] <= pc_inc;
            case (ins[7:0])
              lc3_pkg::TrapGetc: begin
                regs[0] <= key_hold;
                cc <= lc3_pkg::cc_of(key_hold);
              end
              lc3_pkg::TrapOut: begin
                char_valid <= 1'b1;
                char_out   <= regs[0][7:0];
              end
              lc3_pkg::TrapIn: begin
                char_valid <= 1'b1;
                char_out   <= key_hold[7:0];
                regs[0]    <= key_hold;
                cc         <= lc3_pkg::cc_of(key_hold);
              end
              lc3_pkg::TrapHalt: halt_flag <= 1'b1;
              default: begin
              end
            endcase
          end
          default: fault_flag <= 1'b1;
        endcase
        pc <= pcv;
        if (wen) begin
          regs[dr] <= wv;
          cc <= lc3_pkg::cc_of(wv);
        end
      end
    end
  end

  assign pc_now    = pc;
  assign halted    = halt_flag;
  assign fault     = fault_flag;
  assign cond_code = cc;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: LC-3 instruction core testbench
// Builds short programs on the fly: each step is preceded by loads, as
// needed, of the instruction and the data it reads. A shadow copy of the
// core predicts pc, condition code, character and halt/fault flags. The
// monitor checks each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lc3_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] addr;
    logic [15:0] word;
    logic [7:0]  key;
  } core_item_t;

  typedef struct {
    logic [15:0] pc;
    logic        cv;
    logic [7:0]  ch;
    logic        hlt;
    logic        flt;
    logic [2:0]  cc;
  } core_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        operation = 1'b0;
  logic [15:0] load_address = '0;
  logic [15:0] load_word = '0;
  logic [7:0]  key_char = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic [15:0] pc_now;
  logic        char_valid;
  logic [7:0]  char_out;
  logic        halted;
  logic        fault;
  logic [2:0]  cond_code;

  lc3_instruction_core_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .load_address(load_address), .load_word(load_word), .key_char(key_char),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .pc_now(pc_now), .char_valid(char_valid), .char_out(char_out),
    .halted(halted), .fault(fault), .cond_code(cond_code)
  );

  always #5 clk = ~clk;

  // shadow core state
  logic [15:0] shadow_regs [8];
  logic [15:0] shadow_pc;
  logic [2:0]  shadow_cc;
  logic [15:0] shadow_mem [int];
  logic        shadow_halt, shadow_fault, shadow_stepped;

  core_item_t   pending_items [$];
  core_result_t predicted_results [$];
  int errors = 0;
  int n_steps = 0, n_loads = 0, n_chars = 0, n_checked = 0;
  int sender_idle_pct = 0;
  logic took = 1'b0;

  function automatic logic [15:0] sx(logic [15:0] v, int bits);
    logic [15:0] m;
    m = 16'((32'd1 << bits) - 1);
    v &= m;
    if (v[bits-1]) v |= ~m;
    return v;
  endfunction

  function automatic logic [15:0] mem_rd(logic [15:0] a);
    return shadow_mem.exists(a) ? shadow_mem[a] : 16'd0;
  endfunction

  function automatic void put_reg(logic [2:0] r, logic [15:0] v);
    shadow_regs[r] = v;
    shadow_cc = (v == 0) ? CcZero : (v[15] ? CcNeg : CcPos);
  endfunction

  // advance the shadow core by one item and return the expected result
  function automatic core_result_t run_item(core_item_t it);
    core_result_t r;
    logic [15:0] ins, off9, off6, b, tgt;
    logic [2:0] dr, sr1;
    r.cv = 1'b0;
    r.ch = 8'd0;
    if (!it.op) begin
      shadow_mem[it.addr] = it.word;
    end else begin
      shadow_stepped = 1'b1;
      if (!shadow_halt && !shadow_fault) begin
        ins = mem_rd(shadow_pc);
        dr = ins[11:9];
        sr1 = ins[8:6];
        off9 = sx(ins, 9);
        off6 = sx(ins, 6);
        b = ins[5] ? sx(ins, 5) : shadow_regs[ins[2:0]];
        shadow_pc = shadow_pc + 16'd1;
        case (ins[15:12])
          OpBr:  if ((dr & shadow_cc) != 0) shadow_pc = shadow_pc + off9;
          OpAdd: put_reg(dr, shadow_regs[sr1] + b);
          OpLd:  put_reg(dr, mem_rd(shadow_pc + off9));
          OpSt:  shadow_mem[16'(shadow_pc + off9)] = shadow_regs[dr];
          OpJsr: begin
            tgt = ins[11] ? shadow_pc + sx(ins, 11) : shadow_regs[sr1];
            shadow_regs[7] = shadow_pc;
            shadow_pc = tgt;
          end
          OpAnd: put_reg(dr, shadow_regs[sr1] & b);
          OpLdr: put_reg(dr, mem_rd(shadow_regs[sr1] + off6));
          OpStr: shadow_mem[16'(shadow_regs[sr1] + off6)] = shadow_regs[dr];
          OpNot: put_reg(dr, ~shadow_regs[sr1]);
          OpLdi: put_reg(dr, mem_rd(mem_rd(shadow_pc + off9)));
          OpSti: shadow_mem[mem_rd(shadow_pc + off9)] = shadow_regs[dr];
          OpJmp: shadow_pc = shadow_regs[sr1];
          OpLea: put_reg(dr, shadow_pc + off9);
          OpTrap: begin
            shadow_regs[7] = shadow_pc;
            case (ins[7:0])
              TrapGetc: put_reg(3'd0, {8'd0, it.key});
              TrapOut: begin
                r.cv = 1'b1;
                r.ch = shadow_regs[0][7:0];
              end
              TrapIn: begin
                r.cv = 1'b1;
                r.ch = it.key;
                put_reg(3'd0, {8'd0, it.key});
              end
              TrapHalt: shadow_halt = 1'b1;
              default: ;
            endcase
          end
          default: shadow_fault = 1'b1;
        endcase
      end
    end
    r.pc = shadow_pc;
    r.hlt = shadow_halt;
    r.flt = shadow_fault;
    r.cc = shadow_cc;
    return r;
  endfunction

  task automatic push_item(logic op, logic [15:0] a, logic [15:0] w, logic [7:0] k);
    core_item_t it;
    it.op = op;
    it.addr = a;
    it.word = w;
    it.key = k;
    pending_items.push_back(it);
    predicted_results.push_back(run_item(it));
    if (op) n_steps++; else n_loads++;
  endtask

  // load a random word where the program would otherwise read unwritten memory
  task automatic fill_if_unwritten(logic [15:0] a);
    if (!shadow_mem.exists(a)) push_item(1'b0, a, 16'($urandom), 8'($urandom));
  endtask

  // one step: optionally place a fresh instruction at pc, back its data reads
  task automatic step_with(logic place, logic [15:0] ins, logic [7:0] key);
    logic [15:0] w, a;
    if (place || !shadow_mem.exists(shadow_pc)) push_item(1'b0, shadow_pc, ins, 8'($urandom));
    w = shadow_mem[shadow_pc];
    a = shadow_pc + 16'd1 + sx(w, 9);
    if (!shadow_halt && !shadow_fault) begin
      case (w[15:12])
        OpLd, OpSti: fill_if_unwritten(a);
        OpLdi: begin
          fill_if_unwritten(a);
          fill_if_unwritten(shadow_mem[a]);
        end
        OpLdr: fill_if_unwritten(shadow_regs[w[8:6]] + sx(w, 6));
        default: ;
      endcase
    end
    push_item(1'b1, 16'($urandom), 16'($urandom), key);
  endtask

  function automatic logic [15:0] random_instr();
    logic [3:0] ops [14] = '{OpBr, OpAdd, OpLd, OpSt, OpJsr, OpAnd, OpLdr, OpStr,
                             OpNot, OpLdi, OpSti, OpJmp, OpLea, OpTrap};
    logic [15:0] ins;
    logic [7:0] v;
    ins = {ops[$urandom_range(0, 13)], 12'($urandom)};
    if (ins[15:12] == OpTrap) begin
      case ($urandom_range(0, 4))
        0: v = TrapGetc;
        1: v = TrapOut;
        2: v = TrapIn;
        default: begin
          v = 8'($urandom);
          if (v == TrapHalt) v = 8'h26;
        end
      endcase
      ins[7:0] = v;
    end
    return ins;
  endfunction

  task automatic write_start_pc(logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    if (!shadow_stepped) shadow_pc = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || start || predicted_results.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic fieldcheck(string nm, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %h actual %h", $realtime, nm, e, a);
      errors++;
    end
  endtask

  // driver: present the next item at the falling edge
  always @(negedge clk) begin
    if (!rst && (!start || took)) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        operation <= pending_items[0].op;
        load_address <= pending_items[0].addr;
        load_word <= pending_items[0].word;
        key_char <= pending_items[0].key;
        void'(pending_items.pop_front());
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: note transfers and check results
  always @(posedge clk) begin
    took <= start && !busy;
    if (!rst && done) begin
      if (predicted_results.size() == 0) begin
        $display("%0t unexpected result: pc %h", $realtime, pc_now);
        errors++;
      end else begin
        fieldcheck("pc_now", predicted_results[0].pc, pc_now);
        fieldcheck("char_valid", 16'(predicted_results[0].cv), 16'(char_valid));
        fieldcheck("char_out", 16'(predicted_results[0].ch), 16'(char_out));
        fieldcheck("halted", 16'(predicted_results[0].hlt), 16'(halted));
        fieldcheck("fault", 16'(predicted_results[0].flt), 16'(fault));
        fieldcheck("cond_code", 16'(predicted_results[0].cc), 16'(cond_code));
        if (char_valid) n_chars++;
        n_checked++;
        void'(predicted_results.pop_front());
      end
    end
  end

  // stimulus
  initial begin
    logic [15:0] ends [3];
    for (int i = 0; i < 8; i++) shadow_regs[i] = '0;
    shadow_pc = StartPcReset;
    shadow_cc = CcZero;
    shadow_halt = 1'b0;
    shadow_fault = 1'b0;
    shadow_stepped = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // start pc extremes before any step, then a working value
    write_start_pc(16'hFFFF);
    write_start_pc(16'h0000);
    write_start_pc(16'($urandom));

    // directed: memory extremes and each opcode apart from RTI and the reserved one
    push_item(1'b0, 16'h0000, 16'hFFFF, 8'h00);
    push_item(1'b0, 16'hFFFF, 16'h0000, 8'hFF);
    step_with(1'b1, {OpTrap, 4'h0, TrapGetc}, 8'hFF);
    step_with(1'b1, {OpTrap, 4'h0, TrapIn}, 8'h80);
    step_with(1'b1, {OpTrap, 4'h0, TrapOut}, 8'h00);
    step_with(1'b1, {OpAdd, 3'd1, 3'd0, 1'b1, 5'h10}, 8'h00);
    step_with(1'b1, {OpAdd, 3'd2, 3'd1, 1'b0, 2'b00, 3'd0}, 8'h00);
    step_with(1'b1, {OpAnd, 3'd3, 3'd2, 1'b1, 5'h00}, 8'h00);
    step_with(1'b1, {OpNot, 3'd4, 3'd3, 6'h3F}, 8'h00);
    step_with(1'b1, {OpBr, 3'b111, 9'h002}, 8'h00);
    step_with(1'b1, {OpLea, 3'd5, 9'h1FF}, 8'h00);
    step_with(1'b1, {OpLd, 3'd6, 9'h0FF}, 8'h00);
    step_with(1'b1, {OpLdi, 3'd1, 9'h100}, 8'h00);
    step_with(1'b1, {OpLdr, 3'd2, 3'd5, 6'h20}, 8'h00);
    step_with(1'b1, {OpSt, 3'd4, 9'h010}, 8'h00);
    step_with(1'b1, {OpSti, 3'd2, 9'h011}, 8'h00);
    step_with(1'b1, {OpStr, 3'd1, 3'd5, 6'h1F}, 8'h00);
    step_with(1'b1, {OpJsr, 1'b1, 11'h7FF}, 8'h00);
    step_with(1'b1, {OpJsr, 1'b0, 2'b00, 3'd7, 6'h00}, 8'h00);
    step_with(1'b1, {OpJmp, 3'd0, 3'd5, 6'h00}, 8'h00);
    step_with(1'b1, {OpTrap, 4'h0, 8'h22}, 8'h00);
    drain();

    // random phases with sender gaps of 0, 67 and 18 percent
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1) ? 67 : (ph == 3 ? 18 : 0);
      for (int n = 0; n < 48; n++) begin
        if ($urandom_range(0, 9) == 0)
          push_item(1'b0, 16'($urandom), 16'($urandom), 8'($urandom));
        else
          step_with($urandom_range(0, 9) < 7, random_instr(), 8'($urandom));
      end
      drain();
      write_start_pc(ph == 0 ? 16'hFFFF : (ph == 1 ? 16'h0000 : 16'($urandom)));
    end

    // stop the core with halt or a faulting opcode, then poke it
    ends = '{{OpTrap, 4'h0, TrapHalt}, {OpRti, 12'h000}, {OpRes, 12'hFFF}};
    sender_idle_pct = 18;
    step_with(1'b1, ends[$urandom_range(0, 2)], 8'($urandom));
    for (int n = 0; n < 10; n++) begin
      push_item(1'b0, 16'($urandom), 16'($urandom), 8'($urandom));
      step_with(1'b1, random_instr(), 8'($urandom));
    end
    drain();

    $display("Ran %0d steps and %0d loads, %0d results checked, %0d characters out.",
             n_steps, n_loads, n_checked, n_chars);
    if (errors == 0) begin
      $display("[lc3_instruction_core_top] OK");
    end else begin
      $display("[lc3_instruction_core_top] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("timeout");
    $display("[lc3_instruction_core_top] ERROR");
    $finish;
  end

endmodule
